/* design/drt_pkg.sv */
// Shared types and constants for the dirty rectangle merge tracker.
`timescale 1ns / 1ps
package drt_pkg;

	// Table geometry.
	localparam int MAX_RECTS   = 16;
	localparam int IDX_W       = $clog2(MAX_RECTS);
	localparam int CNT_W       = $clog2(MAX_RECTS + 1);
	localparam int COUNT_OUT_W = 5;

	// Field widths.
	localparam int COORD_W  = 14;
	localparam int SIZE_W   = 16;
	localparam int MARGIN_W = 8;
	localparam int EDGE_W   = 17;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TRACKING_ON  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_MARGIN = 1'd1;

	// Reset value of the merge margin register.
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd8;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_MARK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_CMP,
		ST_MERGE,
		ST_FINISH,
		ST_DONE
	} state_t;

	// One stored rectangle.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} rect_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic inc_idx;
		logic wr_merge;
		logic wr_append;
		logic set_flag;
		logic clr_flag;
		logic clr_count;
		logic set_hit;
		logic load_out;
	} drt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    blocked;
		logic    scan_done;
		logic    match;
		logic    table_full;
	} drt_status_t;

endpackage

/* design/drt_ctrl.sv */
// Controller state machine that sequences the table scan for each beat.
`timescale 1ns / 1ps
module drt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  drt_pkg::drt_status_t status,
	output drt_pkg::drt_cmd_t    cmd
);
	import drt_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				unique case (status.action) inside
					ACT_ADD, ACT_QUERY: state_next = status.blocked ? ST_DONE : ST_READ;
					default: state_next = ST_DONE;
				endcase
			end
			ST_READ: begin
				state_next = status.scan_done ? ST_FINISH : ST_CMP;
			end
			ST_CMP: begin
				if (status.match) begin
					state_next = (status.action == ACT_ADD) ? ST_MERGE : ST_DONE;
				end else begin
					state_next = ST_READ;
				end
			end
			ST_MERGE:  state_next = ST_DONE;
			ST_FINISH: state_next = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load_in = in_valid;
			ST_DECIDE: begin
				unique case (status.action)
					ACT_ADD: ;
					ACT_QUERY: cmd.set_hit = status.blocked;
					ACT_MARK: begin
						cmd.set_flag  = 1'b1;
						cmd.clr_count = 1'b1;
					end
					ACT_CLEAR: begin
						cmd.clr_flag  = 1'b1;
						cmd.clr_count = 1'b1;
					end
					default: ;
				endcase
			end
			ST_READ: cmd.rd_en = !status.scan_done;
			ST_CMP: begin
				if (status.match) begin
					cmd.set_hit = (status.action == ACT_QUERY);
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			ST_MERGE: cmd.wr_merge = 1'b1;
			ST_FINISH: begin
				if (status.action == ACT_ADD) begin
					cmd.set_flag  = status.table_full;
					cmd.wr_append = !status.table_full;
				end
			end
			ST_DONE: cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Result beat valid: the output register frees the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* design/drt_datapath.sv */
// Datapath: rectangle store, overlap tests, bounding box and result register.
`timescale 1ns / 1ps
module drt_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [drt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                         action,
	input  logic [drt_pkg::COORD_W-1:0]        x_pos,
	input  logic [drt_pkg::COORD_W-1:0]        y_pos,
	input  logic [drt_pkg::COORD_W-1:0]        rect_width,
	input  logic [drt_pkg::COORD_W-1:0]        rect_height,
	input  drt_pkg::drt_cmd_t                  cmd,
	output drt_pkg::drt_status_t               status,
	output logic                               hit,
	output logic                               redraw_needed,
	output logic                               full_flag,
	output logic [drt_pkg::COUNT_OUT_W-1:0]    rect_count
);
	import drt_pkg::*;

	// Captured input beat.
	action_t            act_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] w_q;
	logic [COORD_W-1:0] h_q;

	// Control and configuration state.
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;
	logic                flag_q;
	logic                tracking_q;
	logic [MARGIN_W-1:0] margin_q;
	logic                hit_q;

	// Store and its registered read port.
	rect_t rect_mem_q [MAX_RECTS];
	rect_t rd_data_q;

	// Result register.
	logic                   out_hit_q;
	logic                   out_redraw_q;
	logic                   out_flag_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	// Edge arithmetic.
	logic [EDGE_W-1:0] in_x_lo;
	logic [EDGE_W-1:0] in_x_hi;
	logic [EDGE_W-1:0] in_y_lo;
	logic [EDGE_W-1:0] in_y_hi;
	logic [EDGE_W-1:0] st_x_lo;
	logic [EDGE_W-1:0] st_x_hi;
	logic [EDGE_W-1:0] st_y_lo;
	logic [EDGE_W-1:0] st_y_hi;
	logic [EDGE_W-1:0] margin_ext;
	logic              merge_ok;
	logic              overlap_ok;
	logic [COORD_W-1:0] box_l;
	logic [COORD_W-1:0] box_t;
	logic [EDGE_W-1:0]  box_r;
	logic [EDGE_W-1:0]  box_b;
	rect_t              merged;
	rect_t              appended;
	rect_t              wr_data;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_en;

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action_t'(action);
			x_q   <= x_pos;
			y_q   <= y_pos;
			w_q   <= rect_width;
			h_q   <= rect_height;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b1;
			margin_q   <= MARGIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRACKING_ON:  tracking_q <= cfg_data[0];
				REG_MERGE_MARGIN: margin_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Full-redraw flag; turning tracking off also raises it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b1;
		end else if (cmd.set_flag ||
			(cfg_we && cfg_index == REG_TRACKING_ON && !cfg_data[0])) begin
			flag_q <= 1'b1;
		end else if (cmd.clr_flag) begin
			flag_q <= 1'b0;
		end
	end

	// Stored count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr_count) begin
			count_q <= '0;
		end else if (cmd.wr_append) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Scan index and query answer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.load_in) begin
			idx_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.set_hit) hit_q <= 1'b1;
		end
	end

	// Edges of the new and the stored rectangle, widened so sums cannot wrap.
	always_comb begin
		in_x_lo    = EDGE_W'(x_q);
		in_y_lo    = EDGE_W'(y_q);
		in_x_hi    = EDGE_W'(x_q) + EDGE_W'(w_q);
		in_y_hi    = EDGE_W'(y_q) + EDGE_W'(h_q);
		st_x_lo    = EDGE_W'(rd_data_q.x);
		st_y_lo    = EDGE_W'(rd_data_q.y);
		st_x_hi    = EDGE_W'(rd_data_q.x) + EDGE_W'(rd_data_q.w);
		st_y_hi    = EDGE_W'(rd_data_q.y) + EDGE_W'(rd_data_q.h);
		margin_ext = EDGE_W'(margin_q);
	end

	// Inclusive test with margin; the margin moves to the other side so no edge goes negative.
	assign merge_ok = (in_x_lo <= st_x_hi + margin_ext) && (in_x_hi + margin_ext >= st_x_lo) &&
	                  (in_y_lo <= st_y_hi + margin_ext) && (in_y_hi + margin_ext >= st_y_lo);

	// Strict overlap: touching edges do not count.
	assign overlap_ok = (in_x_lo < st_x_hi) && (in_x_hi > st_x_lo) &&
	                    (in_y_lo < st_y_hi) && (in_y_hi > st_y_lo);

	// Bounding box of the new and the stored rectangle.
	always_comb begin
		box_l      = (x_q < rd_data_q.x) ? x_q : rd_data_q.x;
		box_t      = (y_q < rd_data_q.y) ? y_q : rd_data_q.y;
		box_r      = (in_x_hi > st_x_hi) ? in_x_hi : st_x_hi;
		box_b      = (in_y_hi > st_y_hi) ? in_y_hi : st_y_hi;
		merged.x   = box_l;
		merged.y   = box_t;
		merged.w   = SIZE_W'(box_r - EDGE_W'(box_l));
		merged.h   = SIZE_W'(box_b - EDGE_W'(box_t));
		appended.x = x_q;
		appended.y = y_q;
		appended.w = SIZE_W'(w_q);
		appended.h = SIZE_W'(h_q);
	end

	// Store write port: merge in place or append at the end.
	assign wr_en   = cmd.wr_merge || cmd.wr_append;
	assign wr_data = cmd.wr_merge ? merged : appended;
	assign wr_addr = cmd.wr_merge ? idx_q[IDX_W-1:0] : count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) rect_mem_q[wr_addr] <= wr_data;
	end

	// Store read port.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_data_q <= rect_mem_q[idx_q[IDX_W-1:0]];
	end

	// Result register, loaded once the step has updated the state.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_hit_q    <= hit_q;
			out_redraw_q <= !tracking_q || flag_q || (count_q != '0);
			out_flag_q   <= flag_q;
			out_count_q  <= COUNT_OUT_W'(count_q);
		end
	end

	// Status to the controller.
	always_comb begin
		status.action     = act_q;
		status.blocked    = !tracking_q || flag_q;
		status.scan_done  = (idx_q == count_q);
		status.match      = (act_q == ACT_ADD) ? merge_ok : overlap_ok;
		status.table_full = (count_q == CNT_W'(MAX_RECTS));
	end

	assign hit           = out_hit_q;
	assign redraw_needed = out_redraw_q;
	assign full_flag     = out_flag_q;
	assign rect_count    = out_count_q;

endmodule

/* design/dirty_rect_merge_tracker.sv */
// Top level of the dirty rectangle merge tracker.
`timescale 1ns / 1ps
// Usage:
// Input beats (action, x_pos, y_pos, rect_width, rect_height) are taken on
// in_valid and in_ready. Each beat yields exactly one result beat (hit,
// redraw_needed, full_flag, rect_count) on out_valid and out_ready.
// Mark-full, clear and blocked adds or queries go from accept through the
// decide state straight to the result register. An add or query scans the
// stored rectangles in turn: each entry is read through the store's single
// registered port and then compared; an add that merges ends its scan early
// and writes the bounding box back in a merge step before the result.
// One beat is in work at a time; in_ready is high whenever the block idles.
// A finished result sits in the output register, so the next beat is taken
// while that result waits; a stalled receiver holds up only the following one.
// Registers are written on cfg_we with cfg_index and cfg_data; the user must
// write them only while idle (the block does not enforce it). Index 0 enables
// tracking (writing 0 raises the full-redraw flag), index 1 sets the merge margin in pixels.
// Reset: tracking on, margin 8, table empty, full-redraw flag set.
// The store needs no clearing pass after reset.
module dirty_rect_merge_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [drt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic [drt_pkg::COORD_W-1:0]        x_pos,
	input  logic [drt_pkg::COORD_W-1:0]        y_pos,
	input  logic [drt_pkg::COORD_W-1:0]        rect_width,
	input  logic [drt_pkg::COORD_W-1:0]        rect_height,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic                               redraw_needed,
	output logic                               full_flag,
	output logic [drt_pkg::COUNT_OUT_W-1:0]    rect_count
);
	import drt_pkg::*;

	drt_cmd_t    cmd;
	drt_status_t status;

	drt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	drt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.cmd           (cmd),
		.status        (status),
		.hit           (hit),
		.redraw_needed (redraw_needed),
		.full_flag     (full_flag),
		.rect_count    (rect_count)
	);

`ifndef NO_ASSERTIONS
	// An accepted beat keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted beat");

	// The reported count never exceeds the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rect_count <= COUNT_OUT_W'(MAX_RECTS))
		else $error("rect_count above table depth");

	// A pending flag or stored rectangles always mean a redraw is needed.
	a_redraw_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (full_flag || rect_count != '0) |-> redraw_needed)
		else $error("redraw_needed low with flag or rectangles pending");

	// The store is only written while a beat is in work.
	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_merge || cmd.wr_append) |-> !in_ready && !cmd.load_out)
		else $error("store written outside a beat");
`endif

endmodule

/* tb/tb_dirty_rect_merge_tracker.sv */
// Self-checking testbench for the dirty rectangle merge tracker.
`timescale 1ns / 1ps
module tb_dirty_rect_merge_tracker;
	import drt_pkg::*;

	// One expected result beat.
	typedef struct {
		logic                   hit;
		logic                   redraw;
		logic                   full;
		logic [COUNT_OUT_W-1:0] count;
	} tracker_status_t;

	// Regions that random rectangles are drawn from.
	typedef enum int {
		AREA_DENSE,
		AREA_SPARSE,
		AREA_WIDE,
		AREA_EDGE
	} area_t;

	localparam int                 RANDOM_BEATS = 1850;
	localparam int                 DRAIN_CYCLES = 48;
	localparam int                 REPORT_LIMIT = 200;
	localparam logic [COORD_W-1:0] COORD_MAX    = '1;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic [1:0]             action      = '0;
	logic [COORD_W-1:0]     x_pos       = '0;
	logic [COORD_W-1:0]     y_pos       = '0;
	logic [COORD_W-1:0]     rect_width  = '0;
	logic [COORD_W-1:0]     rect_height = '0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic                   hit;
	logic                   redraw_needed;
	logic                   full_flag;
	logic [COUNT_OUT_W-1:0] rect_count;

	// Shadow copy of the tracker state and configuration.
	rect_t           shadow_rects [MAX_RECTS];
	int              shadow_count;
	logic            shadow_flag;
	logic            shadow_track;
	int              shadow_margin;
	tracker_status_t pending_status [$];

	int error_count    = 0;
	int useful_beats   = 0;
	int sent_beats     = 0;
	int merge_count    = 0;
	int append_count   = 0;
	int overflow_count = 0;
	int hit_count      = 0;
	int burst_left     = 0;

	dirty_rect_merge_tracker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.redraw_needed(redraw_needed),
		.full_flag    (full_flag),
		.rect_count   (rect_count)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Put the shadow state in its after-reset condition.
	function automatic void reset_shadow();
		shadow_count  = 0;
		shadow_flag   = 1'b1;
		shadow_track  = 1'b1;
		shadow_margin = MARGIN_RESET;
	endfunction

	// Apply one beat to the shadow state and return the result it should produce.
	function automatic tracker_status_t predict_status(action_t act,
			logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
			logic [COORD_W-1:0] pw, logic [COORD_W-1:0] ph);
		tracker_status_t res;
		int   x, y, w, h, sx, sy, sw, sh, lft, top, rgt, btm, i;
		logic done;
		x       = px;
		y       = py;
		w       = pw;
		h       = ph;
		res.hit = 1'b0;
		done    = 1'b0;
		case (act)
			ACT_ADD: begin
				// Adds are dropped while tracking is off or a full redraw is pending.
				if (shadow_track && !shadow_flag) begin
					useful_beats++;
					for (i = 0; i < shadow_count && !done; i++) begin
						sx = shadow_rects[i].x;
						sy = shadow_rects[i].y;
						sw = shadow_rects[i].w;
						sh = shadow_rects[i].h;
						if (x <= sx + sw + shadow_margin && x + w >= sx - shadow_margin &&
						    y <= sy + sh + shadow_margin && y + h >= sy - shadow_margin) begin
							lft = (x < sx) ? x : sx;
							top = (y < sy) ? y : sy;
							rgt = (x + w > sx + sw) ? x + w : sx + sw;
							btm = (y + h > sy + sh) ? y + h : sy + sh;
							shadow_rects[i].x = COORD_W'(lft);
							shadow_rects[i].y = COORD_W'(top);
							shadow_rects[i].w = SIZE_W'(rgt - lft);
							shadow_rects[i].h = SIZE_W'(btm - top);
							done = 1'b1;
							merge_count++;
						end
					end
					if (!done) begin
						if (shadow_count < MAX_RECTS) begin
							shadow_rects[shadow_count].x = px;
							shadow_rects[shadow_count].y = py;
							shadow_rects[shadow_count].w = SIZE_W'(pw);
							shadow_rects[shadow_count].h = SIZE_W'(ph);
							shadow_count++;
							append_count++;
						end else begin
							shadow_flag = 1'b1;
							overflow_count++;
						end
					end
				end
			end
			ACT_QUERY: begin
				useful_beats++;
				if (!shadow_track || shadow_flag) begin
					res.hit = 1'b1;
				end else begin
					// Strict overlap: touching edges do not count.
					for (i = 0; i < shadow_count && !res.hit; i++) begin
						sx = shadow_rects[i].x;
						sy = shadow_rects[i].y;
						sw = shadow_rects[i].w;
						sh = shadow_rects[i].h;
						if (x < sx + sw && x + w > sx && y < sy + sh && y + h > sy)
							res.hit = 1'b1;
					end
				end
				if (res.hit)
					hit_count++;
			end
			ACT_MARK: begin
				useful_beats++;
				shadow_flag  = 1'b1;
				shadow_count = 0;
			end
			default: begin
				useful_beats++;
				shadow_flag  = 1'b0;
				shadow_count = 0;
			end
		endcase
		res.redraw = !shadow_track || shadow_flag || shadow_count > 0;
		res.full   = shadow_flag;
		res.count  = COUNT_OUT_W'(shadow_count);
		return res;
	endfunction

	// Compare one result field; reporting stops after a couple hundred lines.
	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			if (error_count < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Check one accepted result beat against the oldest expectation.
	task automatic check_status();
		tracker_status_t want;
		if (pending_status.size() == 0) begin
			if (error_count < REPORT_LIMIT)
				$display("%0t: result beat with none expected, expected nothing, actual %b%b%b/%0d",
					$time, hit, redraw_needed, full_flag, rect_count);
			error_count++;
		end else begin
			want = pending_status.pop_front();
			compare_field("hit", want.hit, hit);
			compare_field("redraw_needed", want.redraw, redraw_needed);
			compare_field("full_flag", want.full, full_flag);
			compare_field("rect_count", want.count, rect_count);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_status();
	end

	// Receiver stalls: each stretch picks a pattern of its own.
	initial begin : rx_stall
		int mode, span, hold;
		hold = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(32, 400);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: begin
						if (hold > 0) begin
							hold--;
							out_ready <= 1'b0;
						end else begin
							out_ready <= 1'b1;
							if ($urandom_range(0, 3) == 0)
								hold = $urandom_range(5, 30);
						end
					end
				endcase
			end
		end
	end

	// Send one input beat; the sender works in bursts with random gaps between.
	task automatic send_beat(action_t act, logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
			logic [COORD_W-1:0] bw, logic [COORD_W-1:0] bh);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		action      <= act;
		x_pos       <= bx;
		y_pos       <= by;
		rect_width  <= bw;
		rect_height <= bh;
		do @(posedge clk); while (!in_ready);
		pending_status.push_back(predict_status(act, bx, by, bw, bh));
		sent_beats++;
		burst_left--;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one configuration register; only called while the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TRACKING_ON) begin
			shadow_track = data[0];
			if (!data[0])
				shadow_flag = 1'b1;
		end else if (idx == REG_MERGE_MARGIN) begin
			shadow_margin = data;
		end
	endtask

	// Values near both ends of the coordinate range.
	function automatic logic [COORD_W-1:0] border_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return COORD_MAX;
			2: return COORD_W'($urandom_range(0, 15));
			default: return COORD_MAX - COORD_W'($urandom_range(0, 15));
		endcase
	endfunction

	// Draw a random rectangle from the given region.
	task automatic pick_rect(area_t area, output logic [COORD_W-1:0] rx,
			output logic [COORD_W-1:0] ry, output logic [COORD_W-1:0] rw,
			output logic [COORD_W-1:0] rh);
		case (area)
			AREA_DENSE: begin
				rx = COORD_W'($urandom_range(0, 400));
				ry = COORD_W'($urandom_range(0, 400));
				rw = COORD_W'($urandom_range(0, 40));
				rh = COORD_W'($urandom_range(0, 40));
			end
			AREA_SPARSE: begin
				rx = COORD_W'($urandom_range(0, 15) * 1024 + $urandom_range(0, 64));
				ry = COORD_W'($urandom_range(0, 15) * 1024 + $urandom_range(0, 64));
				rw = COORD_W'($urandom_range(0, 100));
				rh = COORD_W'($urandom_range(0, 100));
			end
			AREA_WIDE: begin
				rx = COORD_W'($urandom);
				ry = COORD_W'($urandom);
				rw = COORD_W'($urandom);
				rh = COORD_W'($urandom);
			end
			default: begin
				rx = border_value();
				ry = border_value();
				rw = border_value();
				rh = border_value();
			end
		endcase
	endtask

	// After reset a full redraw is pending: queries hit and adds are dropped.
	task automatic test_reset_state();
		send_beat(ACT_QUERY, '0, '0, COORD_MAX, COORD_MAX);
		send_beat(ACT_ADD, 14'd100, 14'd100, 14'd10, 14'd10);
		send_beat(ACT_CLEAR, COORD_MAX, COORD_MAX, '0, '0);
	endtask

	// Merging within the margin, touching queries, zero sizes, edges below zero.
	task automatic test_merge_and_touch();
		send_beat(ACT_ADD, 14'd100, 14'd100, 14'd50, 14'd50);
		send_beat(ACT_QUERY, 14'd150, 14'd100, 14'd10, 14'd10);
		send_beat(ACT_ADD, 14'd155, 14'd100, 14'd5, 14'd5);
		send_beat(ACT_ADD, 14'd4, 14'd4, 14'd2, 14'd2);
		send_beat(ACT_ADD, '0, '0, '0, '0);
		send_beat(ACT_QUERY, 14'd120, 14'd120, '0, '0);
	endtask

	// Fill the table with disjoint rectangles, then one more sets the flag.
	task automatic test_table_overflow();
		int k;
		wait_idle();
		write_reg(REG_MERGE_MARGIN, '0);
		for (k = 0; k < MAX_RECTS - 3; k++)
			send_beat(ACT_ADD, COORD_W'(1000 * (k + 1)), COORD_W'(1000 * (k + 1)),
				14'd10, 14'd10);
		send_beat(ACT_ADD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_beat(ACT_ADD, 14'd500, 14'd500, 14'd1, 14'd1);
	endtask

	// Tracking off: clear still leaves a redraw pending, queries hit, adds drop.
	task automatic test_tracking_off();
		wait_idle();
		write_reg(REG_TRACKING_ON, '0);
		send_beat(ACT_CLEAR, '0, '0, '0, '0);
		send_beat(ACT_QUERY, 14'd9000, 14'd9000, 14'd1, 14'd1);
		send_beat(ACT_ADD, 14'd20, 14'd20, 14'd5, 14'd5);
		wait_idle();
		write_reg(REG_TRACKING_ON, 8'd1);
		send_beat(ACT_MARK, '0, '0, '0, '0);
	endtask

	// Random phases: each sets the registers, then runs sessions that mostly
	// open with a clear so that adds reach the table.
	task automatic test_random_phases(int beats);
		int                 start, phase, phase_end, roll, len;
		area_t              area;
		logic [COORD_W-1:0] rx, ry, rw, rh;
		logic [CFG_DATA_W-1:0] data;
		logic               track_bit;
		start = sent_beats;
		phase = 0;
		while (sent_beats - start < beats) begin
			wait_idle();
			case (phase)
				0: write_reg(REG_MERGE_MARGIN, '0);
				1: write_reg(REG_MERGE_MARGIN, '1);
				2: write_reg(REG_MERGE_MARGIN, MARGIN_RESET);
				default: write_reg(REG_MERGE_MARGIN, $urandom_range(0, 1) ?
					CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 16)));
			endcase
			track_bit = (phase % 6 != 4);
			data      = CFG_DATA_W'($urandom);
			data[0]   = track_bit;
			write_reg(REG_TRACKING_ON, data);
			phase_end = sent_beats + (track_bit ? 150 : 25);
			while (sent_beats < phase_end && sent_beats - start < beats) begin
				area = area_t'($urandom_range(0, 3));
				len  = $urandom_range(8, 48);
				pick_rect(area, rx, ry, rw, rh);
				if ($urandom_range(0, 9) != 0)
					send_beat(ACT_CLEAR, rx, ry, rw, rh);
				repeat (len) begin
					pick_rect(area, rx, ry, rw, rh);
					roll = $urandom_range(0, 99);
					send_beat(roll < 60 ? ACT_ADD : roll < 90 ? ACT_QUERY :
					          roll < 94 ? ACT_MARK : ACT_CLEAR, rx, ry, rw, rh);
				end
			end
			phase++;
		end
	endtask

	// Main sequence.
	initial begin
		reset_shadow();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_merge_and_touch();
		test_table_overflow();
		test_tracking_off();
		test_random_phases(RANDOM_BEATS);
		wait_idle();
		$display("Covered %0d tracked beats: %0d merges, %0d appends, %0d table overflows.",
			useful_beats, merge_count, append_count, overflow_count);
		$display("Queries hit %0d times; %0d field mismatches seen.", hit_count, error_count);
		if (error_count == 0)
			$display("dirty_rect_merge_tracker test passed");
		else
			$display("dirty_rect_merge_tracker test failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("dirty_rect_merge_tracker test failed");
		$finish;
	end

endmodule
